FILE: rtl/dvs_pkg.sv
package dvs_pkg;

    localparam int CMD_W     = 2;
    localparam int CHAN_W    = 2;
    localparam int PULSE_W   = 24;
    localparam int TIMEOUT_W = 17;
    localparam int MASK_W    = 3;

    localparam int NUM_CHANNELS_DEF = 3;

    localparam logic [TIMEOUT_W-1:0] DEFAULT_TIMEOUT = TIMEOUT_W'(2 * 60 * 1000);
    localparam logic [PULSE_W-1:0]   PULSE_MAX       = {PULSE_W{1'b1}};

    // Item command codes
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_OPEN   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd2;
    localparam logic [CMD_W-1:0] CMD_PULSE  = 2'd3;

    // Channel phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_OPEN = 2'd2;
    localparam logic [1:0] PH_DISP = 2'd3;

    typedef struct packed {
        logic [1:0]           phase;
        logic                 start;
        logic                 cancel;
        logic                 disp;
        logic                 valve;
        logic [PULSE_W-1:0]   target;
        logic [PULSE_W-1:0]   count;
        logic [TIMEOUT_W-1:0] tleft;
        logic                 tout;
    } t_chan_st;

    typedef struct packed {
        logic done;
        logic success;
    } t_ev;

endpackage

FILE: rtl/dvs_in_if.sv
interface dvs_in_if;
    logic                        valid;
    logic                        ready;
    logic [dvs_pkg::CMD_W-1:0]   cmd;
    logic [dvs_pkg::CHAN_W-1:0]  channel;
    logic [dvs_pkg::PULSE_W-1:0] target_pulses;
    logic [dvs_pkg::MASK_W-1:0]  placed_mask;

    modport source (output valid, output cmd, output channel, output target_pulses,
                    output placed_mask, input ready);
    modport sink   (input valid, input cmd, input channel, input target_pulses,
                    input placed_mask, output ready);
endinterface

FILE: rtl/dvs_out_if.sv
interface dvs_out_if;
    logic                       valid;
    logic                       ready;
    logic                       accepted;
    logic [dvs_pkg::MASK_W-1:0] valve_mask;
    logic [dvs_pkg::CHAN_W-1:0] report_channel;
    logic                       done_event;
    logic                       done_success;
    logic                       last;

    modport source (output valid, output accepted, output valve_mask, output report_channel,
                    output done_event, output done_success, output last, input ready);
    modport sink   (input valid, input accepted, input valve_mask, input report_channel,
                    input done_event, input done_success, input last, output ready);
endinterface

FILE: rtl/dvs_cfg_if.sv
interface dvs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [dvs_pkg::TIMEOUT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/dvs_chan_unit.sv
module dvs_chan_unit (
    input  logic [dvs_pkg::CMD_W-1:0]     i_op,
    input  dvs_pkg::t_chan_st             i_cur,
    input  logic                          i_placed,
    input  logic [dvs_pkg::PULSE_W-1:0]   i_target,
    input  logic [dvs_pkg::TIMEOUT_W-1:0] i_timeout,
    output dvs_pkg::t_chan_st             o_nxt,
    output dvs_pkg::t_ev                  o_ev,
    output logic                          o_acc
);

    dvs_pkg::t_chan_st st;

    always_comb begin
        st    = i_cur;
        o_ev  = '0;
        o_acc = 1'b0;
        unique case (i_op)
            dvs_pkg::CMD_TICK: begin
                // count down first, then step the phase
                if (st.tleft != '0) begin
                    st.tleft = st.tleft - 1'b1;
                    if (st.tleft == '0) begin
                        st.tout = 1'b1;
                    end
                end
                unique case (st.phase)
                    dvs_pkg::PH_IDLE: begin
                        if (st.start) begin
                            st.start  = 1'b0;
                            st.cancel = 1'b0;
                            st.count  = '0;
                            st.tleft  = i_timeout;
                            st.tout   = 1'b0;
                            st.phase  = dvs_pkg::PH_WAIT;
                        end
                    end
                    dvs_pkg::PH_WAIT: begin
                        if (i_placed) begin
                            if (!st.disp) begin
                                st.phase = dvs_pkg::PH_OPEN;
                            end else begin
                                st.valve = 1'b1;
                                st.phase = dvs_pkg::PH_DISP;
                            end
                        end
                        if (st.tout) begin
                            st.valve  = 1'b0;
                            st.disp   = 1'b0;
                            st.cancel = 1'b0;
                            st.phase  = dvs_pkg::PH_IDLE;
                            o_ev.done = 1'b1;
                        end
                    end
                    dvs_pkg::PH_OPEN: begin
                        st.valve = 1'b1;
                        st.disp  = 1'b1;
                        st.phase = dvs_pkg::PH_DISP;
                    end
                    default: begin
                        priority if (st.count >= st.target) begin
                            st.count     = '0;
                            st.valve     = 1'b0;
                            st.disp      = 1'b0;
                            st.cancel    = 1'b0;
                            st.phase     = dvs_pkg::PH_IDLE;
                            o_ev.done    = 1'b1;
                            o_ev.success = 1'b1;
                        end else if (st.tout || st.cancel) begin
                            st.valve  = 1'b0;
                            st.disp   = 1'b0;
                            st.cancel = 1'b0;
                            st.phase  = dvs_pkg::PH_IDLE;
                            o_ev.done = 1'b1;
                        end else if (!i_placed) begin
                            st.valve  = 1'b0;
                            st.cancel = 1'b0;
                            st.phase  = dvs_pkg::PH_WAIT;
                        end
                    end
                endcase
            end
            dvs_pkg::CMD_OPEN: begin
                if (st.phase == dvs_pkg::PH_IDLE) begin
                    st.start  = 1'b1;
                    st.target = i_target;
                    o_acc     = 1'b1;
                end
            end
            dvs_pkg::CMD_CANCEL: begin
                if (st.phase != dvs_pkg::PH_IDLE) begin
                    st.cancel = 1'b1;
                end
            end
            default: begin
                if (st.count != dvs_pkg::PULSE_MAX) begin
                    st.count = st.count + 1'b1;
                end
            end
        endcase
        o_nxt = st;
    end

endmodule

FILE: rtl/dispense_valve_sequencer_core.sv
// An open, cancel or pulse item is latched, applied in S_CMD and gives its single result
// through the output register; S_CMD waits while the sink stalls. A tick steps one channel
// per cycle through the shared channel unit in S_STEP, then presents one result per channel
// in S_EMIT, waiting while the sink stalls. A new item is taken only back in S_IDLE.
// Reset (synchronous, active low) idles every channel, clears counts and timers and loads
// the timeout register with 120000; pulse targets hold whatever they had until written.
module dispense_valve_sequencer_core #(
    parameter int NUM_CHANNELS = dvs_pkg::NUM_CHANNELS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dvs_in_if.sink       i_in,
    dvs_out_if.source    o_out,
    dvs_cfg_if.sink      i_cfg
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_CHANNELS - 1);

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;   // take an item
    localparam logic [1:0] S_CMD  = 2'd1;   // apply open, cancel or pulse and post its result
    localparam logic [1:0] S_STEP = 2'd2;   // step channel r_idx on a tick
    localparam logic [1:0] S_EMIT = 2'd3;   // post the tick result of channel r_idx

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;

    // Latched item
    logic [dvs_pkg::CMD_W-1:0]   r_cmd;
    logic [dvs_pkg::PULSE_W-1:0] r_target;
    logic [dvs_pkg::MASK_W-1:0]  r_placed;
    logic                        r_ok;

    logic [dvs_pkg::TIMEOUT_W-1:0] r_timeout;

    // Per-channel state
    logic [1:0]                    r_phase  [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]       r_start;
    logic [NUM_CHANNELS-1:0]       r_cancel;
    logic [NUM_CHANNELS-1:0]       r_disp;
    logic [NUM_CHANNELS-1:0]       r_valve;
    logic [NUM_CHANNELS-1:0]       r_tout;
    logic [dvs_pkg::PULSE_W-1:0]   r_count  [NUM_CHANNELS];
    logic [dvs_pkg::PULSE_W-1:0]   r_ptarget[NUM_CHANNELS];
    logic [dvs_pkg::TIMEOUT_W-1:0] r_tleft  [NUM_CHANNELS];
    dvs_pkg::t_ev                  r_ev     [NUM_CHANNELS];

    // Output register
    logic                        r_ov;
    logic                        r_o_acc;
    logic [dvs_pkg::MASK_W-1:0]  r_o_vm;
    logic [dvs_pkg::CHAN_W-1:0]  r_o_rch;
    logic                        r_o_done;
    logic                        r_o_succ;
    logic                        r_o_last;

    dvs_pkg::t_chan_st w_cur, w_nxt;
    dvs_pkg::t_ev      w_ev;
    logic              w_acc;
    logic              w_placed;
    logic [dvs_pkg::MASK_W-1:0]         w_pl_shift;
    logic [NUM_CHANNELS+dvs_pkg::MASK_W-1:0] w_valve_ext;
    logic [dvs_pkg::MASK_W-1:0]         w_vm;
    logic              w_in_acc;
    logic              w_out_free;
    logic              w_wr;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_acc    = i_in.valid && i_in.ready;
    // The output register can take a new result when empty or being drained now
    assign w_out_free  = !r_ov || o_out.ready;

    // Gather the addressed channel for the shared unit
    always_comb begin
        w_cur.phase  = r_phase[r_idx];
        w_cur.start  = r_start[r_idx];
        w_cur.cancel = r_cancel[r_idx];
        w_cur.disp   = r_disp[r_idx];
        w_cur.valve  = r_valve[r_idx];
        w_cur.target = r_ptarget[r_idx];
        w_cur.count  = r_count[r_idx];
        w_cur.tleft  = r_tleft[r_idx];
        w_cur.tout   = r_tout[r_idx];
    end

    // Only channels 0..2 have a container sensor bit
    assign w_pl_shift  = r_placed >> r_idx;
    assign w_placed    = w_pl_shift[0];
    assign w_valve_ext = (NUM_CHANNELS + dvs_pkg::MASK_W)'(r_valve);
    assign w_vm        = w_valve_ext[dvs_pkg::MASK_W-1:0];

    dvs_chan_unit u_unit (
        .i_op      (r_cmd),
        .i_cur     (w_cur),
        .i_placed  (w_placed),
        .i_target  (r_target),
        .i_timeout (r_timeout),
        .o_nxt     (w_nxt),
        .o_ev      (w_ev),
        .o_acc     (w_acc)
    );

    // Write back: every tick step, and an in-range command once its result can be posted
    assign w_wr = (r_state == S_STEP) || ((r_state == S_CMD) && r_ok && w_out_free);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in.cmd == dvs_pkg::CMD_TICK) begin
                        n_state = S_STEP;
                        n_idx   = '0;
                    end else begin
                        n_state = S_CMD;
                        n_idx   = (32'(i_in.channel) < 32'(NUM_CHANNELS)) ?
                                  IDX_W'(i_in.channel) : '0;
                    end
                end
            end
            S_CMD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_STEP: begin
                // Results wait until every channel has stepped: they carry the final valves
                if (r_idx == IDX_LAST) begin
                    n_state = S_EMIT;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                if (w_out_free) begin
                    if (r_idx == IDX_LAST) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // Latch the item
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd    <= i_in.cmd;
            r_target <= i_in.target_pulses;
            r_placed <= i_in.placed_mask;
            r_ok     <= (32'(i_in.channel) < 32'(NUM_CHANNELS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= dvs_pkg::DEFAULT_TIMEOUT;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_timeout <= i_cfg.data;
        end
    end

    // Channel control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < NUM_CHANNELS; n++) begin
                r_phase[n] <= dvs_pkg::PH_IDLE;
                r_count[n] <= '0;
                r_tleft[n] <= '0;
            end
            r_start  <= '0;
            r_cancel <= '0;
            r_disp   <= '0;
            r_valve  <= '0;
            r_tout   <= '0;
        end else if (w_wr) begin
            r_phase[r_idx]  <= w_nxt.phase;
            r_start[r_idx]  <= w_nxt.start;
            r_cancel[r_idx] <= w_nxt.cancel;
            r_disp[r_idx]   <= w_nxt.disp;
            r_valve[r_idx]  <= w_nxt.valve;
            r_count[r_idx]  <= w_nxt.count;
            r_tleft[r_idx]  <= w_nxt.tleft;
            r_tout[r_idx]   <= w_nxt.tout;
        end
    end

    // Targets and step events carry no reset
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_ptarget[r_idx] <= w_nxt.target;
        end
        if (r_state == S_STEP) begin
            r_ev[r_idx] <= w_ev;
        end
    end

    // Output register: load a result when free, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (((r_state == S_CMD) || (r_state == S_EMIT)) && w_out_free) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_CMD) && w_out_free) begin
            r_o_acc  <= w_acc && r_ok;
            r_o_vm   <= w_vm;
            r_o_rch  <= '0;
            r_o_done <= 1'b0;
            r_o_succ <= 1'b0;
            r_o_last <= 1'b1;
        end else if ((r_state == S_EMIT) && w_out_free) begin
            r_o_acc  <= 1'b0;
            r_o_vm   <= w_vm;
            r_o_rch  <= dvs_pkg::CHAN_W'(r_idx);
            r_o_done <= r_ev[r_idx].done;
            r_o_succ <= r_ev[r_idx].success;
            r_o_last <= (r_idx == IDX_LAST);
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.accepted       = r_o_acc;
    assign o_out.valve_mask     = r_o_vm;
    assign o_out.report_channel = r_o_rch;
    assign o_out.done_event     = r_o_done;
    assign o_out.done_success   = r_o_succ;
    assign o_out.last           = r_o_last;

    // A channel drives its valve only while dispensing
    a_valve_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) && r_valve[r_idx] |-> (r_phase[r_idx] == dvs_pkg::PH_DISP))
        else $error("valve on outside dispensing phase");

    // Success is only ever reported together with a finish
    a_succ_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_o_succ |-> r_o_done && !r_o_acc)
        else $error("success without done event");

    // An acceptance is always the single, final result of its item
    a_acc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_o_acc |-> r_o_last && (r_o_rch == '0))
        else $error("accepted flag on a tick result");

    // A tick goes straight into the channel steps
    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_in.cmd == dvs_pkg::CMD_TICK) |=> (r_state == S_STEP) && (r_idx == '0))
        else $error("tick did not start channel stepping");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int NCH              = dvs_pkg::NUM_CHANNELS_DEF;
    // Extra quiet time after every expected result has drained.
    localparam int SETTLE_CYCLES    = 2 * NCH + 8;
    localparam int STALL_LIMIT      = 4000;
    localparam int ITEMS_PER_PHASE  = 60;
    localparam int NUM_PHASES       = 6;
    localparam int NUM_DIRECTED     = 24;
    localparam int PRESSURE_CYCLES  = 300;
    localparam int PRESSURE_AFTER   = 150;
    localparam int MAX_REPORTS      = 10;

    typedef enum int {EV_NONE, EV_SUCCESS, EV_FAIL} t_chan_event;

    // Shadow copy of one valve channel.
    typedef struct packed {
        logic [1:0]                    phase;
        logic                          start;
        logic                          cancel;
        logic                          disp;
        logic                          valve;
        logic [dvs_pkg::PULSE_W-1:0]   target;
        logic [dvs_pkg::PULSE_W-1:0]   count;
        logic [dvs_pkg::TIMEOUT_W-1:0] tleft;
        logic                          tout;
    } t_valve_chan;

    typedef struct packed {
        logic                         accepted;
        logic [dvs_pkg::MASK_W-1:0]   valve_mask;
        logic [dvs_pkg::CHAN_W-1:0]   report_channel;
        logic                         done_event;
        logic                         done_success;
        logic                         last;
    } t_report;

    // One item to send; typed rows carry their expected accepted/valve_mask.
    typedef struct packed {
        logic [dvs_pkg::CMD_W-1:0]   cmd;
        logic [dvs_pkg::CHAN_W-1:0]  channel;
        logic [dvs_pkg::PULSE_W-1:0] target;
        logic [dvs_pkg::MASK_W-1:0]  placed;
        logic                        typed;
        logic                        acc;
        logic [dvs_pkg::MASK_W-1:0]  vm;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    dvs_in_if  in_bus ();
    dvs_out_if out_bus ();
    dvs_cfg_if cfg_bus ();

    dispense_valve_sequencer_core #(
        .NUM_CHANNELS (NCH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow state of the sequencer and the results it still owes.
    t_valve_chan                   chan_model [NCH];
    logic [dvs_pkg::TIMEOUT_W-1:0] timeout_setting;
    t_report                       report_queue [$];

    int  items_sent      = 0;
    int  results_checked = 0;
    int  mismatches      = 0;
    int  dispenses_ok    = 0;
    int  dispenses_bad   = 0;
    int  cfg_writes      = 0;
    int  quiet_cycles    = 0;
    bit  tx_calm         = 1'b0;
    bit  pressure_done   = 1'b0;

    // ---------------------------------------------------------------
    // Sequencer prediction
    // ---------------------------------------------------------------

    // End a dispense: close the valve, drop the dispensing and cancel flags, go idle.
    function automatic void close_channel(int n);
        chan_model[n].valve  = 1'b0;
        chan_model[n].disp   = 1'b0;
        chan_model[n].cancel = 1'b0;
        chan_model[n].phase  = dvs_pkg::PH_IDLE;
    endfunction

    function automatic logic [dvs_pkg::MASK_W-1:0] valve_drive();
        logic [dvs_pkg::MASK_W-1:0] m;
        m = '0;
        for (int n = 0; n < NCH; n++) m[n] = chan_model[n].valve;
        return m;
    endfunction

    // Advance one channel by one tick.
    function automatic t_chan_event step_channel(int n, logic placed);
        t_chan_event ev;
        ev = EV_NONE;
        case (chan_model[n].phase)
            dvs_pkg::PH_IDLE: begin
                // Start a dispense: clear pulses and arm the timeout.
                if (chan_model[n].start) begin
                    chan_model[n].start  = 1'b0;
                    chan_model[n].cancel = 1'b0;
                    chan_model[n].count  = '0;
                    chan_model[n].tleft  = timeout_setting;
                    chan_model[n].tout   = 1'b0;
                    chan_model[n].phase  = dvs_pkg::PH_WAIT;
                end
            end
            dvs_pkg::PH_WAIT: begin
                // First placement opens; a later one resumes a paused dispense.
                if (placed) begin
                    if (!chan_model[n].disp) begin
                        chan_model[n].phase = dvs_pkg::PH_OPEN;
                    end else begin
                        chan_model[n].valve = 1'b1;
                        chan_model[n].phase = dvs_pkg::PH_DISP;
                    end
                end
                if (chan_model[n].tout) begin
                    close_channel(n);
                    ev = EV_FAIL;
                end
            end
            dvs_pkg::PH_OPEN: begin
                chan_model[n].valve = 1'b1;
                chan_model[n].disp  = 1'b1;
                chan_model[n].phase = dvs_pkg::PH_DISP;
            end
            default: begin
                // Priority: target reached, then timeout or cancel, then removal.
                if (chan_model[n].count >= chan_model[n].target) begin
                    chan_model[n].count = '0;
                    close_channel(n);
                    ev = EV_SUCCESS;
                end else if (chan_model[n].tout || chan_model[n].cancel) begin
                    close_channel(n);
                    ev = EV_FAIL;
                end else if (!placed) begin
                    // Removal only pauses: drop the valve and any cancel, wait again.
                    chan_model[n].valve  = 1'b0;
                    chan_model[n].cancel = 1'b0;
                    chan_model[n].phase  = dvs_pkg::PH_WAIT;
                end
            end
        endcase
        return ev;
    endfunction

    // Apply one accepted item to the shadow state and queue what it must produce.
    function automatic void predict_item(t_stim_row it);
        t_chan_event evs [NCH];
        t_report     rep;
        int          c;
        c = int'(it.channel);
        if (it.cmd == dvs_pkg::CMD_TICK) begin
            // Count down every timer first, then step every channel.
            for (int n = 0; n < NCH; n++) begin
                if (chan_model[n].tleft != '0) begin
                    chan_model[n].tleft = chan_model[n].tleft - 1'b1;
                    if (chan_model[n].tleft == '0) chan_model[n].tout = 1'b1;
                end
            end
            for (int n = 0; n < NCH; n++) evs[n] = step_channel(n, it.placed[n]);
            for (int n = 0; n < NCH; n++) begin
                rep = '0;
                rep.valve_mask     = valve_drive();
                rep.report_channel = dvs_pkg::CHAN_W'(n);
                rep.done_event     = (evs[n] != EV_NONE);
                rep.done_success   = (evs[n] == EV_SUCCESS);
                rep.last           = (n == NCH - 1);
                if (evs[n] == EV_SUCCESS) dispenses_ok++;
                if (evs[n] == EV_FAIL) dispenses_bad++;
                report_queue.push_back(rep);
            end
        end else begin
            rep = '0;
            rep.last = 1'b1;
            if (c < NCH) begin
                case (it.cmd)
                    dvs_pkg::CMD_OPEN: begin
                        // Accept only on an idle channel; a pending start takes the new target.
                        if (chan_model[c].phase == dvs_pkg::PH_IDLE) begin
                            chan_model[c].start  = 1'b1;
                            chan_model[c].target = it.target;
                            rep.accepted = 1'b1;
                        end
                    end
                    dvs_pkg::CMD_CANCEL: begin
                        if (chan_model[c].phase != dvs_pkg::PH_IDLE) chan_model[c].cancel = 1'b1;
                    end
                    default: begin
                        if (chan_model[c].count != dvs_pkg::PULSE_MAX)
                            chan_model[c].count = chan_model[c].count + 1'b1;
                    end
                endcase
            end
            rep.valve_mask = valve_drive();
            if (it.typed) begin
                rep.accepted   = it.acc;
                rep.valve_mask = it.vm;
            end
            report_queue.push_back(rep);
        end
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic t_stim_row mk_row(logic [dvs_pkg::CMD_W-1:0] cmd,
                                         logic [dvs_pkg::CHAN_W-1:0] ch,
                                         logic [dvs_pkg::PULSE_W-1:0] tgt,
                                         logic [dvs_pkg::MASK_W-1:0] placed,
                                         logic typed, logic acc,
                                         logic [dvs_pkg::MASK_W-1:0] vm);
        t_stim_row r;
        r.cmd     = cmd;
        r.channel = ch;
        r.target  = tgt;
        r.placed  = placed;
        r.typed   = typed;
        r.acc     = acc;
        r.vm      = vm;
        return r;
    endfunction

    // Mostly no gap or a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Weighted toward ticks, pulses and opens on real channels so that
    // dispenses run to completion; the rest is cancels and out-of-range noise.
    function automatic t_stim_row random_item();
        t_stim_row it;
        int        r;
        it = '0;
        it.channel = dvs_pkg::CHAN_W'($urandom_range(0, NCH - 1));
        it.target  = dvs_pkg::PULSE_W'($urandom);
        it.placed  = dvs_pkg::MASK_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 38) begin
            it.cmd = dvs_pkg::CMD_TICK;
            // Containers are mostly present.
            for (int b = 0; b < dvs_pkg::MASK_W; b++)
                it.placed[b] = ($urandom_range(0, 99) < 80);
            if ($urandom_range(0, 3) == 0) it.channel = dvs_pkg::CHAN_W'($urandom);
        end else if (r < 62) begin
            it.cmd = dvs_pkg::CMD_PULSE;
        end else if (r < 80) begin
            it.cmd = dvs_pkg::CMD_OPEN;
            case ($urandom_range(0, 7))
                0:       ;
                1:       it.target = dvs_pkg::PULSE_MAX;
                default: it.target = dvs_pkg::PULSE_W'($urandom_range(0, 6));
            endcase
        end else if (r < 90) begin
            it.cmd = dvs_pkg::CMD_CANCEL;
        end else begin
            it.cmd     = dvs_pkg::CMD_W'($urandom_range(1, 3));
            it.channel = {dvs_pkg::CHAN_W{1'b1}};
        end
        return it;
    endfunction

    // Offer one item after a random gap and hold it until the block takes it.
    task automatic offer_item(t_stim_row it);
        int gap;
        if (items_sent % 40 == 0) tx_calm = ($urandom_range(0, 2) == 0);
        gap = tx_calm ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            in_bus.valid = 1'b0;
        end
        @(negedge i_clk);
        in_bus.valid         = 1'b1;
        in_bus.cmd           = it.cmd;
        in_bus.channel       = it.channel;
        in_bus.target_pulses = it.target;
        in_bus.placed_mask   = it.placed;
        do @(posedge i_clk); while (!in_bus.ready);
        predict_item(it);
        items_sent++;
    endtask

    // Drop valid, drain every expected result, then let the block go quiet.
    task automatic settle();
        @(negedge i_clk);
        in_bus.valid = 1'b0;
        while (report_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_timeout(logic [dvs_pkg::TIMEOUT_W-1:0] value);
        @(negedge i_clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.data  = value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        timeout_setting = value;
        cfg_writes++;
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------

    initial begin : stimulus
        t_stim_row                     directed_rows [NUM_DIRECTED];
        logic [dvs_pkg::TIMEOUT_W-1:0] phase_timeouts [NUM_PHASES];

        in_bus.valid         = 1'b0;
        in_bus.cmd           = dvs_pkg::CMD_TICK;
        in_bus.channel       = '0;
        in_bus.target_pulses = '0;
        in_bus.placed_mask   = '0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.data         = '0;

        // Shadow state after reset; targets are only read once an open has set them.
        for (int n = 0; n < NCH; n++) chan_model[n] = '0;
        timeout_setting = dvs_pkg::DEFAULT_TIMEOUT;

        // Directed walk at the reset timeout: refusals, ignored items and the first opens are typed in,
        // the dispense sequences are checked against the shadow state.
        directed_rows = '{
            // open on a channel that does not exist
            mk_row(dvs_pkg::CMD_OPEN,   2'd3, 24'd5,     3'b000, 1'b1, 1'b0, 3'b000),
            // cancel on an idle channel
            mk_row(dvs_pkg::CMD_CANCEL, 2'd0, 24'd0,     3'b111, 1'b1, 1'b0, 3'b000),
            // pulse on a channel that does not exist
            mk_row(dvs_pkg::CMD_PULSE,  2'd3, dvs_pkg::PULSE_MAX,
                   3'b111, 1'b1, 1'b0, 3'b000),
            mk_row(dvs_pkg::CMD_OPEN,   2'd0, 24'd0,     3'b000, 1'b1, 1'b1, 3'b000),
            // second open while the start is pending replaces the target
            mk_row(dvs_pkg::CMD_OPEN,   2'd0, 24'd2,     3'b000, 1'b1, 1'b1, 3'b000),
            mk_row(dvs_pkg::CMD_OPEN,   2'd1, dvs_pkg::PULSE_MAX,
                   3'b000, 1'b1, 1'b1, 3'b000),
            mk_row(dvs_pkg::CMD_OPEN,   2'd2, 24'd1,     3'b000, 1'b1, 1'b1, 3'b000),
            mk_row(dvs_pkg::CMD_TICK,   2'd0, 24'd0,     3'b000, 1'b0, 1'b0, 3'b000),
            // open on a busy channel is refused
            mk_row(dvs_pkg::CMD_OPEN,   2'd0, 24'd9,     3'b000, 1'b1, 1'b0, 3'b000),
            // cancel while waiting for the container is held
            mk_row(dvs_pkg::CMD_CANCEL, 2'd1, 24'd0,     3'b000, 1'b0, 1'b0, 3'b000),
            mk_row(dvs_pkg::CMD_TICK,   2'd0, 24'd0,     3'b111, 1'b0, 1'b0, 3'b000),
            mk_row(dvs_pkg::CMD_TICK,   2'd0, 24'd0,     3'b111, 1'b0, 1'b0, 3'b000),
            mk_row(dvs_pkg::CMD_PULSE,  2'd2, 24'd0,     3'b000, 1'b0, 1'b0, 3'b000),
            mk_row(dvs_pkg::CMD_PULSE,  2'd0, 24'd0,     3'b000, 1'b0, 1'b0, 3'b000),
            mk_row(dvs_pkg::CMD_PULSE,  2'd0, 24'd0,     3'b000, 1'b0, 1'b0, 3'b000),
            // two successes and the held cancel failing channel 1
            mk_row(dvs_pkg::CMD_TICK,   2'd0, 24'd0,     3'b111, 1'b0, 1'b0, 3'b000),
            mk_row(dvs_pkg::CMD_OPEN,   2'd1, dvs_pkg::PULSE_MAX,
                   3'b000, 1'b0, 1'b0, 3'b000),
            mk_row(dvs_pkg::CMD_TICK,   2'd0, 24'd0,     3'b000, 1'b0, 1'b0, 3'b000),
            mk_row(dvs_pkg::CMD_TICK,   2'd0, 24'd0,     3'b010, 1'b0, 1'b0, 3'b000),
            mk_row(dvs_pkg::CMD_TICK,   2'd0, 24'd0,     3'b010, 1'b0, 1'b0, 3'b000),
            // container removed mid-dispense: pause, then resume
            mk_row(dvs_pkg::CMD_TICK,   2'd3, dvs_pkg::PULSE_MAX,
                   3'b000, 1'b0, 1'b0, 3'b000),
            mk_row(dvs_pkg::CMD_TICK,   2'd0, 24'd0,     3'b010, 1'b0, 1'b0, 3'b000),
            mk_row(dvs_pkg::CMD_CANCEL, 2'd1, 24'd0,     3'b000, 1'b0, 1'b0, 3'b000),
            mk_row(dvs_pkg::CMD_TICK,   2'd0, 24'd0,     3'b010, 1'b0, 1'b0, 3'b000)
        };

        // Extremes first: immediate timeout, no timeout, longest; then short ones.
        phase_timeouts = '{
            dvs_pkg::TIMEOUT_W'(1), dvs_pkg::TIMEOUT_W'(0), {dvs_pkg::TIMEOUT_W{1'b1}},
            dvs_pkg::TIMEOUT_W'(6), dvs_pkg::TIMEOUT_W'($urandom_range(2, 40)),
            dvs_pkg::TIMEOUT_W'(3)
        };

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++) offer_item(directed_rows[i]);

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            write_timeout(phase_timeouts[p]);
            repeat (ITEMS_PER_PHASE) offer_item(random_item());
        end
        settle();

        $display("Sent %0d items over %0d timeout settings; %0d results checked.",
                 items_sent, cfg_writes, results_checked);
        $display("Dispenses ended: %0d on target, %0d by timeout or cancel; sink hold-off %s.",
                 dispenses_ok, dispenses_bad, pressure_done ? "applied" : "not reached");
        if (mismatches == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    // ---------------------------------------------------------------
    // Result sink: random stalls, calm stretches, and one long hold-off
    // once enough results have gone by, so the block backs up into its input.
    // ---------------------------------------------------------------

    initial begin : result_sink
        int hold_left;
        int cyc;
        bit calm;
        hold_left = 0;
        cyc = 0;
        calm = 1'b0;
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc % 200 == 0) calm = ($urandom_range(0, 3) == 0);
            if (!pressure_done && results_checked >= PRESSURE_AFTER) begin
                pressure_done = 1'b1;
                hold_left = PRESSURE_CYCLES;
            end else if (hold_left == 0 && !calm && $urandom_range(0, 99) < 30) begin
                hold_left = pick_gap();
            end
            if (hold_left > 0) begin
                out_bus.ready = 1'b0;
                hold_left--;
            end else begin
                out_bus.ready = 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result check: compare each taken result with the oldest expectation.
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin : result_check
        t_report seen;
        t_report want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            seen.accepted       = out_bus.accepted;
            seen.valve_mask     = out_bus.valve_mask;
            seen.report_channel = out_bus.report_channel;
            seen.done_event     = out_bus.done_event;
            seen.done_success   = out_bus.done_success;
            seen.last           = out_bus.last;
            if (report_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"%0t: result with nothing expected: ",
                              "acc=%b vm=%b ch=%0d done=%b ok=%b last=%b"},
                             $realtime, seen.accepted, seen.valve_mask, seen.report_channel,
                             seen.done_event, seen.done_success, seen.last);
            end else begin
                want = report_queue.pop_front();
                if (seen !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"%0t: result %0d differs: ",
                                  "exp acc=%b vm=%b ch=%0d done=%b ok=%b last=%b, ",
                                  "got acc=%b vm=%b ch=%0d done=%b ok=%b last=%b"},
                                 $realtime, results_checked,
                                 want.accepted, want.valve_mask, want.report_channel,
                                 want.done_event, want.done_success, want.last,
                                 seen.accepted, seen.valve_mask, seen.report_channel,
                                 seen.done_event, seen.done_success, seen.last);
                end
            end
            results_checked++;
        end
    end

    // ---------------------------------------------------------------
    // Watchdog: end the run if no bus completes a handshake for too long.
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles, %0d results outstanding.",
                     quiet_cycles, report_queue.size());
            $display("testbench failed");
            $finish;
        end
    end

endmodule
